/* sv/rwg_pkg.sv */
// Shared widths, codes and transaction types for the read window grouper.
`default_nettype none

package rwg_pkg;

    localparam int CHROM_W   = 16;
    localparam int RID_W     = 32;
    localparam int POS_W     = 32;
    localparam int SEQ_W     = 40;
    localparam int LEN_W     = 16;
    localparam int KIND_W    = 4;
    localparam int CLEN_W    = 28;
    localparam int GEND_W    = 40;
    localparam int WLEN_W    = 40;
    localparam int TOTAL_W   = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_CIGAR  = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam logic [KIND_W-1:0] CIG_M  = 4'd0;
    localparam logic [KIND_W-1:0] CIG_D  = 4'd2;
    localparam logic [KIND_W-1:0] CIG_N  = 4'd3;
    localparam logic [KIND_W-1:0] CIG_EQ = 4'd7;
    localparam logic [KIND_W-1:0] CIG_X  = 4'd8;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_TOTAL_READS   = 1'b1;

    typedef enum logic {
        ITEM_HEADER,
        ITEM_END
    } item_kind_t;

    typedef struct packed {
        item_kind_t           kind;
        logic [CHROM_W-1:0]   chrom;
        logic [RID_W-1:0]     rid;
        logic [POS_W-1:0]     pos;
        logic [SEQ_W-1:0]     start;
        logic [LEN_W-1:0]     len;
        logic                 fold_valid;
        logic [GEND_W-1:0]    fold_end;
    } queue_entry_t;

    typedef struct packed {
        logic [CHROM_W-1:0]   chrom;
        logic [SEQ_W-1:0]     left_pos;
        logic [SEQ_W-1:0]     right_pos;
        logic [RID_W-1:0]     first_read;
        logic [RID_W-1:0]     last_rid;
        logic [POS_W-1:0]     genome_start;
        logic [GEND_W-1:0]    genome_end;
    } window_result_t;

    function automatic logic cigar_on_ref(input logic [KIND_W-1:0] kind);
        logic hit;
        case (kind)
            CIG_M, CIG_D, CIG_N, CIG_EQ, CIG_X: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

/* sv/rwg_front.sv */
// Front end: accepts input transactions, tracks the open read and its span, queues headers and ends.
`default_nettype none

module rwg_front import rwg_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_opcode,
    input  wire logic [CHROM_W-1:0]   s_chrom,
    input  wire logic [RID_W-1:0]     s_read_index,
    input  wire logic [POS_W-1:0]     s_ref_pos,
    input  wire logic [SEQ_W-1:0]     s_seq_start,
    input  wire logic [LEN_W-1:0]     s_seq_len,
    input  wire logic [KIND_W-1:0]    s_cigar_kind,
    input  wire logic [CLEN_W-1:0]    s_cigar_len,
    input  wire logic                 push_ready,
    output logic                      push_valid,
    output queue_entry_t              push_entry
);

    logic                 read_pending_reg, read_pending_next;
    logic [POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [GEND_W-1:0]    cur_span_reg, cur_span_next;

    logic                 accept;
    logic [GEND_W:0]      end_sum;
    logic [GEND_W-1:0]    fold_end;
    logic [GEND_W:0]      span_sum;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    assign end_sum  = {(GEND_W+1-POS_W)'(0), cur_pos_reg} + {1'b0, cur_span_reg}
                      - (GEND_W+1)'(1);
    assign span_sum = {1'b0, cur_span_reg} + {(GEND_W+1-CLEN_W)'(0), s_cigar_len};

    always_comb begin
        if (cur_span_reg == '0) begin
            fold_end = {(GEND_W-POS_W)'(0), cur_pos_reg};
        end else if (end_sum[GEND_W]) begin
            fold_end = '1;
        end else begin
            fold_end = end_sum[GEND_W-1:0];
        end
    end

    always_comb begin
        push_valid             = accept && (s_opcode == OP_HEADER || s_opcode == OP_END);
        push_entry.kind        = (s_opcode == OP_END) ? ITEM_END : ITEM_HEADER;
        push_entry.chrom       = s_chrom;
        push_entry.rid         = s_read_index;
        push_entry.pos         = s_ref_pos;
        push_entry.start       = s_seq_start;
        push_entry.len         = s_seq_len;
        push_entry.fold_valid  = read_pending_reg;
        push_entry.fold_end    = fold_end;
    end

    always_comb begin
        read_pending_next = read_pending_reg;
        cur_pos_next      = cur_pos_reg;
        cur_span_next     = cur_span_reg;
        if (accept) begin
            case (s_opcode)
                OP_HEADER: begin
                    read_pending_next = 1'b1;
                    cur_pos_next      = s_ref_pos;
                    cur_span_next     = '0;
                end
                OP_CIGAR: begin
                    if (read_pending_reg && cigar_on_ref(s_cigar_kind)) begin
                        cur_span_next = span_sum[GEND_W] ? '1 : span_sum[GEND_W-1:0];
                    end
                end
                OP_END: begin
                    read_pending_next = 1'b0;
                end
                default: begin
                    read_pending_next = read_pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pending_reg <= 1'b0;
        end else begin
            read_pending_reg <= read_pending_next;
        end
        cur_pos_reg  <= cur_pos_next;
        cur_span_reg <= cur_span_next;
    end

endmodule

`default_nettype wire

/* sv/rwg_queue.sv */
// Short transaction queue between the front end and the window engine.
`default_nettype none

module rwg_queue import rwg_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    input  wire queue_entry_t push_entry,
    output logic           push_ready,
    output logic           pop_valid,
    output queue_entry_t   pop_entry,
    input  wire logic      pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/rwg_back.sv */
// Window engine: joins or closes windows and holds the result register.
`default_nettype none

module rwg_back import rwg_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    input  wire queue_entry_t         pop_entry,
    output logic                      pop_ready,
    input  wire logic [WLEN_W-1:0]    window_length,
    input  wire logic [TOTAL_W-1:0]   total_reads,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output window_result_t            m_result
);

    logic                 window_open_reg, window_open_next;
    logic [CHROM_W-1:0]   win_chrom_reg, win_chrom_next;
    logic [SEQ_W-1:0]     win_left_reg, win_left_next;
    logic [RID_W-1:0]     win_first_reg, win_first_next;
    logic [RID_W-1:0]     win_last_reg, win_last_next;
    logic [SEQ_W-1:0]     last_start_reg, last_start_next;
    logic [LEN_W-1:0]     last_len_reg, last_len_next;
    logic [POS_W-1:0]     win_gen_start_reg, win_gen_start_next;
    logic [GEND_W-1:0]    win_gen_end_reg, win_gen_end_next;
    logic                 m_valid_reg, m_valid_next;
    window_result_t       result_reg, result_next;

    logic                 take;
    logic                 joins;
    logic                 emit;
    logic                 sep;
    logic [SEQ_W:0]       limit;
    logic [GEND_W-1:0]    gen_end_eff;
    logic [SEQ_W-1:0]     right_pos;

    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_result  = result_reg;

    assign limit = {1'b0, win_left_reg} + {(SEQ_W+1-WLEN_W)'(0), window_length};
    assign joins = window_open_reg && (pop_entry.chrom == win_chrom_reg)
                   && ({1'b0, pop_entry.start} < limit);
    assign emit  = take && window_open_reg
                   && (pop_entry.kind == ITEM_END || !joins);

    assign gen_end_eff = (pop_entry.fold_valid && pop_entry.fold_end > win_gen_end_reg)
                         ? pop_entry.fold_end : win_gen_end_reg;

    assign sep       = ({1'b0, win_last_reg} + (RID_W+1)'(1))
                       < {(RID_W+1-TOTAL_W)'(0), total_reads};
    assign right_pos = last_start_reg + {(SEQ_W-LEN_W)'(0), last_len_reg}
                       - SEQ_W'(1) + {(SEQ_W-1)'(0), sep};

    always_comb begin
        window_open_next   = window_open_reg;
        win_chrom_next     = win_chrom_reg;
        win_left_next      = win_left_reg;
        win_first_next     = win_first_reg;
        win_last_next      = win_last_reg;
        last_start_next    = last_start_reg;
        last_len_next      = last_len_reg;
        win_gen_start_next = win_gen_start_reg;
        win_gen_end_next   = win_gen_end_reg;
        m_valid_next       = m_valid_reg;
        result_next        = result_reg;

        if (pop_ready) begin
            m_valid_next = emit;
        end
        if (emit) begin
            result_next.chrom        = win_chrom_reg;
            result_next.left_pos     = win_left_reg;
            result_next.right_pos    = right_pos;
            result_next.first_read   = win_first_reg;
            result_next.last_rid     = win_last_reg;
            result_next.genome_start = win_gen_start_reg;
            result_next.genome_end   = gen_end_eff;
        end

        if (take) begin
            case (pop_entry.kind)
                ITEM_HEADER: begin
                    win_last_next   = pop_entry.rid;
                    last_start_next = pop_entry.start;
                    last_len_next   = pop_entry.len;
                    if (joins) begin
                        win_gen_end_next = gen_end_eff;
                    end else begin
                        window_open_next   = 1'b1;
                        win_chrom_next     = pop_entry.chrom;
                        win_left_next      = pop_entry.start;
                        win_first_next     = pop_entry.rid;
                        win_gen_start_next = pop_entry.pos;
                        win_gen_end_next   = '0;
                    end
                end
                ITEM_END: begin
                    win_gen_end_next = gen_end_eff;
                    window_open_next = 1'b0;
                end
                default: begin
                    window_open_next = window_open_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_open_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            window_open_reg <= window_open_next;
            m_valid_reg     <= m_valid_next;
        end
        win_chrom_reg     <= win_chrom_next;
        win_left_reg      <= win_left_next;
        win_first_reg     <= win_first_next;
        win_last_reg      <= win_last_next;
        last_start_reg    <= last_start_next;
        last_len_reg      <= last_len_next;
        win_gen_start_reg <= win_gen_start_next;
        win_gen_end_reg   <= win_gen_end_next;
        result_reg        <= result_next;
    end

endmodule

`default_nettype wire

/* sv/read_window_grouper_unit.sv */
// Top level of the read window grouper: configuration registers and the front, queue and engine.
//
// Input channel (s_*): a sorted stream of read headers (opcode 0), each followed by the
// CIGAR operations of that read (opcode 1), closed by an end transaction (opcode 2).
// Output channel (m_*): one result per closed window: chromosome, sequence span l..r,
// first and last read id, genomic start and genomic end.
// A header that opens a new window, or an end transaction, closes the open window.
// Throughput: one input transaction per cycle while the queue is not full.
// A closed window is registered in a queue entry and then in the result register before it
// is valid on m_*; it waits longer while the receiver stalls.
// When m_ready is low with a result pending, the result register holds; the queue of
// QUEUE_DEPTH entries then fills with headers and end transactions and s_ready drops. CIGAR
// transactions are absorbed by the front end and never enter the queue.
// Configuration: APB writes at 0x0 (window_length) and 0x8 (total_reads), 64-bit data,
// pready tied high; write only while the stream is idle.
// Reset (aresetn low, synchronous) empties the queue, drops any open window and read,
// and returns window_length and total_reads to 1.
`default_nettype none

module read_window_grouper_unit import rwg_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_opcode,
    input  wire logic [CHROM_W-1:0]   s_chrom,
    input  wire logic [RID_W-1:0]     s_read_index,
    input  wire logic [POS_W-1:0]     s_ref_pos,
    input  wire logic [SEQ_W-1:0]     s_seq_start,
    input  wire logic [LEN_W-1:0]     s_seq_len,
    input  wire logic [KIND_W-1:0]    s_cigar_kind,
    input  wire logic [CLEN_W-1:0]    s_cigar_len,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CHROM_W-1:0]        m_out_chrom,
    output logic [SEQ_W-1:0]          m_left_pos,
    output logic [SEQ_W-1:0]          m_right_pos,
    output logic [RID_W-1:0]          m_first_read,
    output logic [RID_W-1:0]          m_last_rid,
    output logic [POS_W-1:0]          m_genome_start,
    output logic [GEND_W-1:0]         m_genome_end
);

    logic [WLEN_W-1:0]    window_length_reg, window_length_next;
    logic [TOTAL_W-1:0]   total_reads_reg, total_reads_next;
    logic                 cfg_write;
    logic                 reg_sel;

    logic                 push_valid, push_ready;
    queue_entry_t         push_entry;
    logic                 pop_valid, pop_ready;
    queue_entry_t         pop_entry;
    window_result_t       result;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        window_length_next = window_length_reg;
        total_reads_next   = total_reads_reg;
        if (cfg_write) begin
            case (reg_sel)
                REG_WINDOW_LENGTH: window_length_next = pwdata[WLEN_W-1:0];
                REG_TOTAL_READS:   total_reads_next   = pwdata[TOTAL_W-1:0];
                default:           window_length_next = window_length_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WINDOW_LENGTH: prdata = {(PDATA_W-WLEN_W)'(0), window_length_reg};
            REG_TOTAL_READS:   prdata = {(PDATA_W-TOTAL_W)'(0), total_reads_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WLEN_W'(1);
            total_reads_reg   <= TOTAL_W'(1);
        end else begin
            window_length_reg <= window_length_next;
            total_reads_reg   <= total_reads_next;
        end
    end

    rwg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_chrom      (s_chrom),
        .s_read_index (s_read_index),
        .s_ref_pos    (s_ref_pos),
        .s_seq_start  (s_seq_start),
        .s_seq_len    (s_seq_len),
        .s_cigar_kind (s_cigar_kind),
        .s_cigar_len  (s_cigar_len),
        .push_ready   (push_ready),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    rwg_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    rwg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop_ready     (pop_ready),
        .window_length (window_length_reg),
        .total_reads   (total_reads_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (result)
    );

    assign m_out_chrom    = result.chrom;
    assign m_left_pos     = result.left_pos;
    assign m_right_pos    = result.right_pos;
    assign m_first_read   = result.first_read;
    assign m_last_rid     = result.last_rid;
    assign m_genome_start = result.genome_start;
    assign m_genome_end   = result.genome_end;

endmodule

`default_nettype wire

/* sv/rwg_checker.sv */
// Port-level checks for the read window grouper and their bind to the top level.
`default_nettype none

module rwg_checker import rwg_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    input  wire logic [PDATA_W-1:0]   prdata,
    input  wire logic                 pready,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [SEQ_W-1:0]     m_left_pos,
    input  wire logic [SEQ_W-1:0]     m_right_pos,
    input  wire logic [GEND_W-1:0]    m_genome_end
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_window_length_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[3] == REG_WINDOW_LENGTH)
        |=> (paddr[3] != REG_WINDOW_LENGTH
             || prdata[WLEN_W-1:0] == $past(pwdata[WLEN_W-1:0])))
        else $error("window_length readback mismatch");

    a_stall_holds_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    a_stall_holds_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready)
        |=> ($stable(m_left_pos) && $stable(m_right_pos) && $stable(m_genome_end)))
        else $error("result changed while stalled");

endmodule

bind read_window_grouper_unit rwg_checker u_rwg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_left_pos   (m_left_pos),
    .m_right_pos  (m_right_pos),
    .m_genome_end (m_genome_end)
);

`default_nettype wire
